/* design/gtc_pkg.sv */
// Shared types, codes and constants for the guide error trigger capture block.
package gtc_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // action codes
  localparam logic [1:0] ACT_OFFSET = 2'd0;
  localparam logic [1:0] ACT_DROP   = 2'd1;
  localparam logic [1:0] ACT_PUSH   = 2'd2;

  // origin kinds of a logged frame
  localparam logic [1:0] KIND_HISTORY = 2'd0;
  localparam logic [1:0] KIND_TRIGGER = 2'd1;
  localparam logic [1:0] KIND_FOLLOW  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LOGGING_ENABLED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIG_ON_PX      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIG_ON_REL     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TRIG_ON_DROP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_PX       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESH_REL      = 3'd5;

  localparam logic [1:0]  FOLLOW_FRAMES       = 2'd2;
  localparam logic [15:0] STATS_WARMUP_FRAMES = 16'd10;
  localparam logic [15:0] THRESH_RESET        = 16'd1024;
  localparam logic [15:0] EVENT_RESET         = 16'd1;

  typedef struct packed {
    logic        logging_enabled;
    logic        trig_on_px;
    logic        trig_on_rel;
    logic        trig_on_drop;
    logic [15:0] thresh_px;
    logic [15:0] thresh_rel;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] frame_id;
    logic [15:0] distance;
    logic [15:0] current_error;
    logic        guiding;
    logic        calib_or_guiding;
    logic        paused;
    logic        settling;
    logic [15:0] frames_seen;
  } item_t;

endpackage

/* design/gtc_trigger.sv */
// Trigger decision for offset and dropped-frame words.
module gtc_trigger
  import gtc_pkg::*;
(
  input  cfg_t  cfg,
  input  item_t item,
  output logic  trig
);

  logic [15:0] cur_eff;
  logic [31:0] rel_rhs;
  logic [31:0] rel_lhs;
  logic        px_ok;
  logic        rel_ok;
  logic        test_ok;
  logic        offset_ok;
  logic        drop_ok;

  // zero error counts as one LSB
  assign cur_eff = (item.current_error == 16'd0) ? 16'd1 : item.current_error;
  assign rel_rhs = {16'd0, cfg.thresh_rel} * {16'd0, cur_eff};
  assign rel_lhs = {8'd0, item.distance, 8'd0};
  assign px_ok   = item.distance > cfg.thresh_px;
  assign rel_ok  = rel_lhs > rel_rhs;

  always_comb begin
    if (cfg.trig_on_px && cfg.trig_on_rel) begin
      test_ok = px_ok && rel_ok;
    end else if (cfg.trig_on_px) begin
      test_ok = px_ok;
    end else begin
      test_ok = rel_ok;
    end
  end

  assign offset_ok = cfg.logging_enabled && (cfg.trig_on_px || cfg.trig_on_rel)
                     && item.guiding && !item.paused && !item.settling
                     && (item.frames_seen >= STATS_WARMUP_FRAMES) && test_ok;
  assign drop_ok   = cfg.logging_enabled && cfg.trig_on_drop
                     && item.calib_or_guiding && !item.paused;

  always_comb begin
    case (item.action)
      ACT_OFFSET: trig = offset_ok;
      ACT_DROP:   trig = drop_ok;
      default:    trig = 1'b0;
    endcase
  end

endmodule

/* design/gtc_event_ctrl.sv */
// Event state: frame history, follow-on count and event number.
module gtc_event_ctrl
  import gtc_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  item_t                              item,
  input  logic                               trig,
  input  logic                               advance,
  output logic                               produces,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0] emit_start,
  output logic [HISTORY_DEPTH-1:0][31:0]     hist_ids,
  output logic [1:0]                         emit_kind,
  output logic [15:0]                        emit_event
);

  localparam int IW = $clog2(HISTORY_DEPTH + 1);

  // valid entries always sit at the top of the history
  logic [IW-1:0] hist_count;
  logic [1:0]    follow;
  logic [15:0]   event_count;
  logic          is_frame;
  logic          fresh;

  assign is_frame   = (item.action == ACT_OFFSET) || (item.action == ACT_DROP);
  assign produces   = is_frame && (trig || (follow != 2'd0));
  assign fresh      = trig && (follow == 2'd0);
  assign emit_kind  = trig ? KIND_TRIGGER : KIND_FOLLOW;
  assign emit_event = event_count;
  assign emit_start = fresh ? (IW'(HISTORY_DEPTH) - hist_count) : IW'(HISTORY_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_count  <= '0;
      follow      <= 2'd0;
      event_count <= EVENT_RESET;
    end else if (advance) begin
      case (item.action) inside
        ACT_PUSH: begin
          if (hist_count != IW'(HISTORY_DEPTH)) begin
            hist_count <= hist_count + IW'(1);
          end
        end
        ACT_OFFSET, ACT_DROP: begin
          if (trig) begin
            follow <= FOLLOW_FRAMES;
          end else if (follow != 2'd0) begin
            follow <= follow - 2'd1;
            if (follow == 2'd1) begin
              event_count <= event_count + 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // shift toward index zero, newest at the top
  always_ff @(posedge clk) begin
    if (advance && (item.action == ACT_PUSH)) begin
      for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
        hist_ids[i] <= hist_ids[i+1];
      end
      hist_ids[HISTORY_DEPTH-1] <= item.frame_id;
    end
  end

endmodule

/* design/gtc_emitter.sv */
// Result register: holds one burst of logged frames and sends it word by word.
module gtc_emitter
  import gtc_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic [$clog2(HISTORY_DEPTH+1)-1:0] load_start,
  input  logic [HISTORY_DEPTH-1:0][31:0]     hist_ids,
  input  logic [31:0]                        cur_id,
  input  logic [1:0]                         cur_kind,
  input  logic [15:0]                        event_num,
  output logic                               free,
  input  logic                               m_tready,
  output logic                               m_tvalid,
  output logic [OUT_TDATA_W-1:0]             m_tdata,   // log_frame_id, event_number
  output logic [1:0]                         m_tuser,   // origin_kind
  output logic                               m_tlast
);

  localparam int IW = $clog2(HISTORY_DEPTH + 1);

  logic          busy;
  logic [IW-1:0] slot;
  logic [31:0]   slot_ids [0:HISTORY_DEPTH];
  logic [1:0]    kind;
  logic [15:0]   ev;
  logic          at_end;

  // slot HISTORY_DEPTH holds the current frame, lower slots the history
  assign at_end   = (slot == IW'(HISTORY_DEPTH));
  assign free     = !busy || (m_tready && at_end);
  assign m_tvalid = busy;
  assign m_tlast  = at_end;
  assign m_tdata  = {ev, slot_ids[slot]};
  assign m_tuser  = at_end ? kind : KIND_HISTORY;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (load) begin
      busy <= 1'b1;
      slot <= load_start;
    end else if (busy && m_tready) begin
      if (at_end) begin
        busy <= 1'b0;
      end else begin
        slot <= slot + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        slot_ids[i] <= hist_ids[i];
      end
      slot_ids[HISTORY_DEPTH] <= cur_id;
      kind <= cur_kind;
      ev   <= event_num;
    end
  end

endmodule

/* design/guide_error_trigger_capture_core.sv */
// Guide error trigger capture. Words on the slave side are offset frames, dropped
// frames or history pushes (tuser selects which); each is held in an input
// register, judged against the trigger settings and turned into a burst of log
// words in the result register. A burst sends one word per cycle while m_tready
// is high: a fresh trigger sends the stored history frames, oldest first, then
// the trigger frame (up to HISTORY_DEPTH + 1 words); a retrigger or a follow-on
// frame sends one word; other words send nothing. The result register's drain
// sets the rate: an item with a burst waits for the current burst's last word,
// and the next word is taken while the current burst is still being sent.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
module guide_error_trigger_capture_core
  import gtc_pkg::*;
#(
  parameter int HISTORY_DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // frame_id, distance, current_error, guiding, calib_or_guiding, paused,
  // settling, frames_seen, zero pad
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]             s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // log_frame_id, event_number
  output logic [1:0]             m_tuser,   // origin_kind
  output logic                   m_tlast
);

  localparam int IW = $clog2(HISTORY_DEPTH + 1);

  cfg_t                          cfg;
  item_t                         item_in;
  item_t                         item;
  logic                          in_valid;
  logic                          advance;
  logic                          trig;
  logic                          produces;
  logic                          emit_free;
  logic [IW-1:0]                 emit_start;
  logic [HISTORY_DEPTH-1:0][31:0] hist_ids;
  logic [1:0]                    emit_kind;
  logic [15:0]                   emit_event;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.logging_enabled <= 1'b0;
      cfg.trig_on_px      <= 1'b0;
      cfg.trig_on_rel     <= 1'b0;
      cfg.trig_on_drop    <= 1'b0;
      cfg.thresh_px       <= THRESH_RESET;
      cfg.thresh_rel      <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOGGING_ENABLED: cfg.logging_enabled <= cfg_data[0];
        REG_TRIG_ON_PX:      cfg.trig_on_px      <= cfg_data[0];
        REG_TRIG_ON_REL:     cfg.trig_on_rel     <= cfg_data[0];
        REG_TRIG_ON_DROP:    cfg.trig_on_drop    <= cfg_data[0];
        REG_THRESH_PX:       cfg.thresh_px       <= cfg_data;
        REG_THRESH_REL:      cfg.thresh_rel      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    item_in.action           = s_tuser;
    item_in.frame_id         = s_tdata[31:0];
    item_in.distance         = s_tdata[47:32];
    item_in.current_error    = s_tdata[63:48];
    item_in.guiding          = s_tdata[64];
    item_in.calib_or_guiding = s_tdata[65];
    item_in.paused           = s_tdata[66];
    item_in.settling         = s_tdata[67];
    item_in.frames_seen      = s_tdata[83:68];
  end

  // drop silent words at once; a burst waits for the result register
  assign advance  = in_valid && (!produces || emit_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_in;
    end
  end

  gtc_trigger u_trigger (
    .cfg  (cfg),
    .item (item),
    .trig (trig)
  );

  gtc_event_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_event_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .trig       (trig),
    .advance    (advance),
    .produces   (produces),
    .emit_start (emit_start),
    .hist_ids   (hist_ids),
    .emit_kind  (emit_kind),
    .emit_event (emit_event)
  );

  gtc_emitter #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && produces),
    .load_start (emit_start),
    .hist_ids   (hist_ids),
    .cur_id     (item.frame_id),
    .cur_kind   (emit_kind),
    .event_num  (emit_event),
    .free       (emit_free),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

/* design/gtc_checker.sv */
// Port-level checks for the guide error trigger capture block, with its bind.
module gtc_checker
  import gtc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser,
  input logic                   m_tlast
);

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // a stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
    && $stable(m_tlast))
    else $error("stalled result word changed");

  // history frames always precede the frame that closes the burst
  a_history_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_HISTORY) |-> !m_tlast)
    else $error("history frame marked last");

  // a burst continues in the next cycle under one event number
  a_burst_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid
    && (m_tdata[47:32] == $past(m_tdata[47:32])))
    else $error("burst broken or event number changed inside burst");

endmodule

bind guide_error_trigger_capture_core gtc_checker u_gtc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
